>>> rtl/core/sail_pkg.sv
// Shared types and constants for the source address interval lookup block.
// No dependencies; imported by the top level and by the port checker.
`default_nettype none

package sail_pkg;

  localparam int ADDR_W      = 64;
  localparam int LEN_W       = 4;
  localparam int IDX_W       = 10;
  localparam int ENTRY_W     = ADDR_W + LEN_W;
  localparam int IN_TDATA_W  = 136;  // start, length, address padded to bytes
  localparam int OUT_TDATA_W = 16;   // found, index padded to bytes

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_RANGE = 2'd2,
    KIND_EXACT = 2'd3
  } kind_t;

  localparam logic [ADDR_W-1:0] NO_SOURCE = '1;

endpackage

`default_nettype wire

>>> rtl/core/sail_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sail_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/source_address_interval_lookup_top.sv
// Top level of the source address interval lookup: table load and binary search.
// Depends on sail_pkg and sail_ram.
//
//  channel | ports             | tdata / tuser (lowest bit first)
//  --------+-------------------+-----------------------------------------------
//  input   | in_tvalid/tready  | tuser: kind; tdata: entry_start, entry_length,
//          |                   |   query_address, 4 zero bits
//  result  | out_tvalid/tready | tdata: found, entry_index, 5 zero bits
//
// Clear and load transfers leave the block idle, ready for the next input. A query
// reads the first and the last entry, then makes P binary search probes, and no new
// input is taken until its result is registered, P being at most clog2(entries + 1),
// 11 for a full table; each probe is one read of the table RAM, whose single
// read port sets the pace. Out-of-bounds and empty-table queries skip the probes.
// Reset clears the entry count and the result valid flag; the table itself is not
// cleared. A stalled result holds the block before its next query result, while
// clear and load transfers still proceed.
`default_nettype none

module source_address_interval_lookup_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [sail_pkg::IN_TDATA_W-1:0] in_tdata,  // entry_start, entry_length, query_address
  input  wire logic [1:0]                      in_tuser,  // kind
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [sail_pkg::OUT_TDATA_W-1:0]     out_tdata  // found, entry_index
);

  import sail_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_BOUND,
    S_PROBE,
    S_HOLD
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     left_r;
  logic [CW-1:0]     right_r;
  logic [CW-1:0]     mid_r;
  logic [ADDR_W-1:0] addr_r;
  logic              exact_r;
  logic              res_found_r;
  logic [IDX_W-1:0]  res_index_r;
  logic              out_tvalid_r;
  logic [IDX_W-1:0]  out_index_r;
  logic              out_found_r;

  kind_t             in_kind;
  logic [ADDR_W-1:0] in_start;
  logic [LEN_W-1:0]  in_len;
  logic [ADDR_W-1:0] in_addr;
  logic              in_xfer;

  logic              ram_we;
  logic [AW-1:0]     ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic [ADDR_W-1:0] s;
  logic [LEN_W-1:0]  s_len;
  logic [ADDR_W:0]   diff;
  logic              s_gt;
  logic              s_eq;
  logic              hit;
  logic              beyond;
  logic [CW-1:0]     left_nxt;
  logic [CW-1:0]     right_nxt;
  logic [CW-1:0]     mid_nxt;
  logic [CW-1:0]     last_idx;

  assign in_kind  = kind_t'(in_tuser);
  assign in_start = in_tdata[ADDR_W-1:0];
  assign in_len   = in_tdata[ADDR_W +: LEN_W];
  assign in_addr  = in_tdata[ENTRY_W +: ADDR_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign ram_we = in_xfer && (in_kind == KIND_LOAD) && (in_start != NO_SOURCE)
                  && (count_r < CW'(TABLE_DEPTH));

  // Compare the entry read last cycle against the query address
  assign s     = ram_rd_data[ADDR_W-1:0];
  assign s_len = ram_rd_data[ADDR_W +: LEN_W];
  assign diff  = {1'b0, addr_r} - {1'b0, s};
  assign s_gt  = diff[ADDR_W];
  assign s_eq  = (s == addr_r);

  always_comb begin
    if (exact_r) begin
      hit    = s_eq;
      beyond = !s_gt && !s_eq;
    end else begin
      hit    = !s_gt && (diff[ADDR_W-1:LEN_W] == '0) && (diff[LEN_W-1:0] < s_len);
      beyond = !s_gt && ((diff[ADDR_W-1:LEN_W] != '0) || (diff[LEN_W-1:0] > s_len));
    end
  end

  assign left_nxt  = s_gt ? left_r : mid_r + CW'(1);
  assign right_nxt = s_gt ? mid_r : right_r;
  assign mid_nxt   = left_nxt + ((right_nxt - left_nxt) >> 1);
  assign last_idx  = count_r - CW'(1);

  always_comb begin
    unique case (state_r)
      S_FIRST: ram_rd_addr = last_idx[AW-1:0];
      S_BOUND: ram_rd_addr = AW'(count_r >> 1);
      S_PROBE: ram_rd_addr = mid_nxt[AW-1:0];
      default: ram_rd_addr = '0;
    endcase
  end

  sail_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(count_r[AW-1:0]),
    .wr_data({in_len, in_start}),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // the hold state reloads the result register itself
      if (out_tready && (state_r != S_HOLD)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            addr_r  <= in_addr;
            exact_r <= (in_kind == KIND_EXACT);
            unique case (in_kind) inside
              KIND_CLEAR: count_r <= '0;
              KIND_LOAD: begin
                if (ram_we) begin
                  count_r <= count_r + CW'(1);
                end
              end
              KIND_RANGE, KIND_EXACT: begin
                res_found_r <= 1'b0;
                res_index_r <= '0;
                // entry 0 is being read this cycle
                state_r <= (count_r == '0) ? S_HOLD : S_FIRST;
              end
              default: ;
            endcase
          end
        end
        S_FIRST: begin
          state_r <= s_gt ? S_HOLD : S_BOUND;
        end
        S_BOUND: begin
          left_r  <= '0;
          right_r <= count_r;
          mid_r   <= count_r >> 1;
          state_r <= beyond ? S_HOLD : S_PROBE;
        end
        S_PROBE: begin
          if (hit) begin
            res_found_r <= 1'b1;
            res_index_r <= IDX_W'(mid_r);
            state_r     <= S_HOLD;
          end else if (left_nxt < right_nxt) begin
            left_r  <= left_nxt;
            right_r <= right_nxt;
            mid_r   <= mid_nxt;
          end else begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_found_r  <= res_found_r;
            out_index_r  <= res_index_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - IDX_W - 1){1'b0}}, out_index_r, out_found_r};

endmodule

`default_nettype wire

>>> rtl/core/sail_checker.sv
// Port-level checker for the source address interval lookup, bound to the top.
// Depends on sail_pkg.
`default_nettype none

module sail_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [1:0]                       in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [sail_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import sail_pkg::*;

  logic in_xfer;
  logic query_xfer;
  logic clear_xfer;

  assign in_xfer    = in_tvalid && in_tready;
  assign query_xfer = in_xfer && ((in_tuser == KIND_RANGE) || (in_tuser == KIND_EXACT));
  assign clear_xfer = in_xfer && (in_tuser == KIND_CLEAR);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("not-found result carries a nonzero index");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    query_xfer |=> !in_tready)
    else $error("input accepted while a query is searching");

  a_clear_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    clear_xfer |=> in_tready)
    else $error("clear did not complete in one cycle");

endmodule

bind source_address_interval_lookup_top sail_checker u_sail_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire

>>> dv/tb_source_address_interval_lookup_top.sv
// Testbench for source_address_interval_lookup_top: table loads, range and exact lookups.
// Depends on sail_pkg and the block's RTL; predicts each lookup answer in-line and
// compares result transfers in order.
`default_nettype none

module tb_source_address_interval_lookup_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sail_pkg::*;

  localparam int TABLE_DEPTH = 1024;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } lookup_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // entry_start, entry_length, query_address, pad
  logic [1:0]             in_tuser   = '0;  // kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // found, entry_index, pad

  // Predicted table contents
  logic [ADDR_W-1:0] start_tab [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_tab   [TABLE_DEPTH];
  int unsigned       entry_total = 0;

  lookup_result_t pending_answers[$];
  int unsigned    mismatch_count = 0;
  int unsigned    items_sent     = 0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_idle_pct  = 0;
  int unsigned    recv_hold      = 0;

  source_address_interval_lookup_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Binary search over the predicted table, same probe order as the block
  function automatic lookup_result_t search_table(input logic exact, input logic [ADDR_W-1:0] a);
    lookup_result_t    res;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] last;
    res = '0;
    if (entry_total == 0) return res;
    last = start_tab[entry_total-1];
    if (a < start_tab[0]) return res;
    if (exact) begin
      if (a > last) return res;
    end else if (a > last && (a - last) > {{(ADDR_W-LEN_W){1'b0}}, len_tab[entry_total-1]}) begin
      return res;
    end
    lo = 0;
    hi = entry_total;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      s = start_tab[mid];
      if (exact ? (s == a) : (s <= a && (a - s) < {{(ADDR_W-LEN_W){1'b0}}, len_tab[mid]})) begin
        res.found = 1'b1;
        res.index = IDX_W'(mid);
        return res;
      end
      if (s > a) hi = mid;
      else lo = mid + 1;
    end
    return res;
  endfunction

  function automatic void predict_transfer(input kind_t k, input logic [ADDR_W-1:0] st,
                                           input logic [LEN_W-1:0] ln,
                                           input logic [ADDR_W-1:0] qa);
    case (k)
      KIND_CLEAR: entry_total = 0;
      KIND_LOAD: begin
        if (st != NO_SOURCE && entry_total < TABLE_DEPTH) begin
          start_tab[entry_total] = st;
          len_tab[entry_total]   = ln;
          entry_total++;
        end
      end
      KIND_RANGE: pending_answers = {pending_answers, search_table(1'b0, qa)};
      default:    pending_answers = {pending_answers, search_table(1'b1, qa)};
    endcase
  endfunction

  // Predict on every input transfer, check every result transfer
  always @(posedge clk) begin : check_proc
    lookup_result_t got;
    lookup_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict_transfer(kind_t'(in_tuser), in_tdata[63:0], in_tdata[67:64], in_tdata[131:68]);
      if (out_tvalid && out_tready) begin
        got.found = out_tdata[0];
        got.index = out_tdata[10:1];
        if (pending_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result found=%b index=%0d", $realtime, got.found,
                     got.index);
        end else begin
          want = pending_answers.pop_front();
          if (got.found !== want.found || got.index !== want.index) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected found=%b index=%0d, got found=%b index=%0d",
                       $realtime, want.found, want.index, got.found, got.index);
          end
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      out_tready <= 1'b0;
      recv_hold  <= recv_hold - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input kind_t k, input logic [ADDR_W-1:0] st,
                           input logic [LEN_W-1:0] ln, input logic [ADDR_W-1:0] qa);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {4'b0, qa, ln, st};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and hold until every predicted answer has come back
  task automatic wait_answers_done();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(KIND_RANGE, '0, '0, '0);
    send_item(KIND_EXACT, '1, 4'hF, '1);
    send_item(KIND_LOAD, NO_SOURCE, 4'h3, '0);
    send_item(KIND_LOAD, 64'h0, 4'h0, '1);
    send_item(KIND_LOAD, 64'h10, 4'hF, '0);
    send_item(KIND_LOAD, 64'h20, 4'h1, '0);
    send_item(KIND_LOAD, 64'h8000_0000_0000_0000, 4'h8, '0);
    send_item(KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFF0, 4'hF, '0);
    send_item(KIND_RANGE, '0, '0, 64'h0);
    send_item(KIND_RANGE, '0, '0, 64'h1F);
    send_item(KIND_RANGE, '0, '0, 64'h20);
    send_item(KIND_RANGE, '0, '0, 64'h8000_0000_0000_0007);
    send_item(KIND_RANGE, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(KIND_RANGE, '0, '0, '1);
    send_item(KIND_EXACT, '0, '0, 64'h10);
    send_item(KIND_EXACT, '0, '0, 64'hFFFF_FFFF_FFFF_FFF0);
    send_item(KIND_EXACT, '0, '0, '1);
    send_item(KIND_EXACT, '0, '0, 64'h0);
    send_item(KIND_CLEAR, '1, 4'hF, '1);
    send_item(KIND_LOAD, 64'h100, 4'h4, '0);
    send_item(KIND_RANGE, '0, '0, 64'hFF);
    send_item(KIND_RANGE, '0, '0, 64'h104);
    send_item(KIND_RANGE, '0, '0, 64'h105);
    send_item(KIND_EXACT, '0, '0, 64'h100);
  endtask

  task automatic test_full_table();
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] starts [TABLE_DEPTH];
    logic [LEN_W-1:0]  lens   [TABLE_DEPTH];
    int unsigned       i;
    int unsigned       q;
    send_item(KIND_CLEAR, '0, '0, '0);
    cur = {24'h0, 8'($urandom), $urandom};
    for (i = 0; i < TABLE_DEPTH; i++) begin
      starts[i] = cur;
      lens[i]   = LEN_W'($urandom);
      send_item(KIND_LOAD, cur, lens[i], '0);
      cur = cur + $urandom_range(1, 24);
    end
    // table is full: both of these are dropped
    send_item(KIND_LOAD, cur, 4'h5, '0);
    send_item(KIND_LOAD, NO_SOURCE, 4'h5, '0);
    send_item(KIND_EXACT, '0, '0, starts[TABLE_DEPTH-1]);
    send_item(KIND_EXACT, '0, '0, starts[0]);
    send_item(KIND_EXACT, '0, '0, cur);
    send_item(KIND_RANGE, '0, '0, starts[TABLE_DEPTH-1] + lens[TABLE_DEPTH-1]);
    for (q = 0; q < 40; q++) begin
      i = $urandom_range(TABLE_DEPTH - 1);
      send_item($urandom_range(1) ? KIND_RANGE : KIND_EXACT, '0, '0,
                starts[i] + $urandom_range(0, lens[i]));
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned       target;
    int unsigned       n_entries;
    int unsigned       n_queries;
    int unsigned       i;
    int unsigned       pick;
    int unsigned       region;
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] nxt;
    logic [ADDR_W-1:0] a;
    logic [LEN_W-1:0]  ln;
    logic              in_order;
    logic [ADDR_W-1:0] starts[$];
    logic [LEN_W-1:0]  lens[$];
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 8) begin
        // noise: fully random items
        repeat (4) send_item(kind_t'($urandom_range(3)), {$urandom, $urandom},
                             LEN_W'($urandom), {$urandom, $urandom});
        continue;
      end
      if ($urandom_range(99) < 85) begin
        send_item(KIND_CLEAR, {$urandom, $urandom}, LEN_W'($urandom), {$urandom, $urandom});
        starts.delete();
        lens.delete();
      end
      if ($urandom_range(99) < 5) n_entries = 0;
      else if ($urandom_range(99) < 90) n_entries = $urandom_range(1, 24);
      else n_entries = $urandom_range(25, 200);
      region = $urandom_range(2);
      case (region)
        0:       cur = 64'($urandom_range(0, 63));
        1:       cur = {$urandom, $urandom};
        default: cur = NO_SOURCE - $urandom_range(0, n_entries * 12 + 20);
      endcase
      in_order = ($urandom_range(99) >= 10);
      for (i = 0; i < n_entries; i++) begin
        ln = LEN_W'($urandom);
        if ($urandom_range(99) < 3) begin
          send_item(KIND_LOAD, NO_SOURCE, ln, {$urandom, $urandom});
          continue;
        end
        if (!in_order) cur = {$urandom, $urandom};
        send_item(KIND_LOAD, cur, ln, {$urandom, $urandom});
        starts = {starts, cur};
        lens   = {lens, ln};
        if (in_order) begin
          nxt = cur + (($urandom_range(99) < 80) ? ln + $urandom_range(0, 8)
                                                  : $urandom_range(0, 20));
          // stop before the addresses wrap
          if (nxt < cur) break;
          cur = nxt;
        end
      end
      n_queries = $urandom_range(4, 16);
      for (i = 0; i < n_queries; i++) begin
        if (starts.size() == 0) begin
          a = {$urandom, $urandom};
        end else begin
          pick = $urandom_range(starts.size() - 1);
          case ($urandom_range(9))
            0, 1, 2, 3: a = starts[pick] + $urandom_range(0, lens[pick]);
            4:          a = starts[pick];
            5:          a = starts[pick] - 1;
            6:          a = {$urandom, $urandom};
            7:          a = starts[0] - $urandom_range(1, 100);
            8:          a = starts[starts.size()-1] + lens[starts.size()-1] + $urandom_range(0, 3);
            default:    a = $urandom_range(1) ? '1 : '0;
          endcase
        end
        send_item(($urandom_range(99) < 60) ? KIND_RANGE : KIND_EXACT,
                  {$urandom, $urandom}, LEN_W'($urandom), a);
      end
    end
  endtask

  // Long result stall while queries keep coming, so the input stalls too
  task automatic test_receiver_holdoff();
    int unsigned saved_idle;
    int unsigned i;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    send_item(KIND_CLEAR, '0, '0, '0);
    for (i = 0; i < 12; i++) send_item(KIND_LOAD, 64'h4000 + 16 * i, LEN_W'(i + 4), '0);
    recv_hold = 400;
    for (i = 0; i < 40; i++)
      send_item(($urandom_range(1) != 0) ? KIND_RANGE : KIND_EXACT, '0, '0,
                64'h4000 + $urandom_range(0, 200));
    send_idle_pct = saved_idle;
    wait_answers_done();
  endtask

  task automatic test_sender_pause();
    int unsigned i;
    send_item(KIND_CLEAR, '0, '0, '0);
    for (i = 0; i < 6; i++) send_item(KIND_LOAD, 64'h900 + 10 * i, 4'h9, '0);
    for (i = 0; i < 8; i++) send_item(KIND_RANGE, '0, '0, 64'h900 + $urandom_range(0, 70));
    wait_answers_done();
    for (i = 0; i < 8; i++) send_item(KIND_EXACT, '0, '0, 64'h900 + 10 * $urandom_range(0, 6));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 65;
    test_directed();
    test_full_table();
    test_random_traffic(250);

    send_idle_pct = 65;
    recv_idle_pct = 15;
    test_random_traffic(250);
    test_receiver_holdoff();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(250);
    test_sender_pause();

    wait_answers_done();
    repeat (40) @(posedge clk);
    if (pending_answers.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", pending_answers.size());
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
